// ----- hw/rtl/sgfb_pkg.sv -----
// Shared types, constants and the sigmoid table generator for the sigmoid forward/backward block.
`timescale 1ns / 1ps

package sgfb_pkg;

   // Field widths of one item.
   localparam int X_W    = 16;
   localparam int GRAD_W = 16;
   localparam int Y_W    = 17;
   localparam int S_W    = 16;

   // One in Q1.15, the upper bound of the sigmoid value.
   localparam logic [S_W-1:0] S_ONE = 16'h8000;

   // Gradient product: s*(1-s) fits 29 bits, times |grad| fits 45 bits.
   localparam int DS_W       = 29;
   localparam int AG_W       = 16;
   localparam int P_W        = DS_W + AG_W;
   localparam int GRAD_SHIFT = 30;

   // Mode codes.
   localparam logic MODE_FORWARD  = 1'b0;
   localparam logic MODE_BACKWARD = 1'b1;

   // Sideband that travels alongside the sigmoid pipeline.
   typedef struct packed {
      logic                     mode;
      logic                     last;
      logic signed [GRAD_W-1:0] grad;
   } side_type;

   // Restoring long division, used only while the table is built at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Table point k: round(32768 * sigmoid(8*k/segs)), evaluated at elaboration.
   // e^t is a truncated Taylor sum in Q32.
   function automatic logic [S_W-1:0] rom_entry(input int unsigned k, input int unsigned segs);
      logic [63:0] one;
      logic [63:0] term;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] q;
      int unsigned n;
      one  = 64'd1 << 32;
      term = one;
      e    = one;
      for (n = 1; n < 400 && term != 64'd0; n++) begin
         term = udiv64(term * 64'(8 * k), 64'(segs) * 64'(n));
         e    = e + term;
      end
      d = e + one;
      q = udiv64((e << 16) + d, d << 1);
      return S_W'(q);
   endfunction

endpackage

// ----- hw/rtl/sgfb_sigmoid.sv -----
// Five-stage sigmoid pipeline: absolute value, scaling, table lookup, interpolation, sign fold.
`timescale 1ns / 1ps

module sgfb_sigmoid #(
   parameter int TABLE_SEGMENTS = 64,
   parameter int FRAC_BITS      = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic signed [sgfb_pkg::X_W-1:0]     in_x,
   input  sgfb_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic [sgfb_pkg::S_W-1:0]            out_s,
   output sgfb_pkg::side_type                  out_side
);
   import sgfb_pkg::*;

   localparam int STAGES = 5;
   localparam int SH     = FRAC_BITS + 3;
   localparam int TAB_W  = $clog2(TABLE_SEGMENTS + 1);
   localparam int POS_W  = (X_W + TAB_W > SH + 1) ? X_W + TAB_W : SH + 1;
   localparam int PROD_W = S_W + SH;
   localparam int unsigned RANGE = 1 << SH;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (SH - 1);

   // Constant sigmoid table over 0 <= |x| <= 8.
   logic [S_W-1:0] rom_tbl [TABLE_SEGMENTS+1];

   for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_rom
      localparam logic [S_W-1:0] ENTRY = rom_entry(k, TABLE_SEGMENTS);
      assign rom_tbl[k] = ENTRY;
   end

   logic [STAGES-1:0] vld_ff;
   side_type          side_ff [STAGES];

   // Valid bits move with the data whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // Sideband shift line.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Stage 1: magnitude of x and the saturation test.
   logic [X_W-1:0] a1_in;
   logic           sat1_in;
   logic [X_W-1:0] a1_ff;
   logic           neg1_ff;
   logic           sat1_ff;

   assign a1_in   = in_x[X_W-1] ? X_W'(-in_x) : X_W'(in_x);
   assign sat1_in = {16'd0, a1_in} >= 32'(RANGE);

   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff   <= a1_in;
         neg1_ff <= in_x[X_W-1];
         sat1_ff <= sat1_in;
      end
   end

   // Stage 2: scale the magnitude onto the table grid.
   logic [POS_W-1:0] pos2_in;
   logic [POS_W-1:0] pos2_ff;
   logic             neg2_ff;
   logic             sat2_ff;

   assign pos2_in = POS_W'(a1_ff) * POS_W'(TABLE_SEGMENTS);

   always_ff @(posedge clock) begin
      if (advance) begin
         pos2_ff <= pos2_in;
         neg2_ff <= neg1_ff;
         sat2_ff <= sat1_ff;
      end
   end

   // Stage 3: split into segment index and remainder, read both end points.
   logic [TAB_W-1:0] idx3;
   logic [TAB_W-1:0] idx3_next;
   logic [SH-1:0]    r3_in;
   logic [S_W-1:0]   lo3_ff;
   logic [S_W-1:0]   hi3_ff;
   logic [SH-1:0]    r3_ff;
   logic             neg3_ff;
   logic             sat3_ff;

   assign idx3      = sat2_ff ? TAB_W'(TABLE_SEGMENTS - 1) : TAB_W'(pos2_ff >> SH);
   assign idx3_next = TAB_W'(idx3 + 1'b1);
   assign r3_in     = sat2_ff ? '0 : pos2_ff[SH-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         lo3_ff  <= rom_tbl[idx3];
         hi3_ff  <= rom_tbl[idx3_next];
         r3_ff   <= r3_in;
         neg3_ff <= neg2_ff;
         sat3_ff <= sat2_ff;
      end
   end

   // Stage 4: slope times remainder. The table rises, so the slope is never negative.
   logic [PROD_W-1:0] prod4_in;
   logic [PROD_W-1:0] prod4_ff;
   logic [S_W-1:0]    lo4_ff;
   logic [S_W-1:0]    hi4_ff;
   logic              neg4_ff;
   logic              sat4_ff;

   assign prod4_in = PROD_W'(hi3_ff - lo3_ff) * PROD_W'(r3_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         prod4_ff <= prod4_in;
         lo4_ff   <= lo3_ff;
         hi4_ff   <= hi3_ff;
         neg4_ff  <= neg3_ff;
         sat4_ff  <= sat3_ff;
      end
   end

   // Stage 5: round the interpolation half up and mirror for negative x.
   logic [PROD_W-1:0] step5;
   logic [S_W-1:0]    v5;
   logic [S_W-1:0]    s5_in;
   logic [S_W-1:0]    s5_ff;

   assign step5 = (prod4_ff + HALF) >> SH;
   assign v5    = sat4_ff ? hi4_ff : S_W'(lo4_ff + S_W'(step5));
   assign s5_in = neg4_ff ? S_W'(S_ONE - v5) : v5;

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_ff <= s5_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_s     = s5_ff;
   assign out_side  = side_ff[STAGES-1];

endmodule

// ----- hw/rtl/sigmoid_forward_backward.sv -----
// Top level: streaming logistic sigmoid (mode 0) and its gradient product (mode 1).
`timescale 1ns / 1ps

// Takes one item per clock unless the output stalls and returns one result per item, in order.
// The pipeline holds eight registers: five stages for the table lookup and interpolation of the
// sigmoid, two multiplier stages for s*(1-s)*grad and the output register. Sigmoid is a linear
// interpolation over TABLE_SEGMENTS+1 table points on |x| in 0..8, saturating beyond; x and grad
// are signed Q(FRAC_BITS). Mode 0 returns s in Q1.15 (0..32768); mode 1 returns s*(1-s)*grad in
// Q(FRAC_BITS), rounded half away from zero and saturated to 16 bits. A result that waits at the
// output stalls the whole pipeline; no item is lost or repeated. The last flag passes through
// unchanged.
module sigmoid_forward_backward #(
   parameter int TABLE_SEGMENTS = 64,
   parameter int FRAC_BITS      = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x [15:0], grad [31:16]
   input  logic        req_tuser,   // mode [0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // y [16:0], zero [23:17]
   output logic        rsp_tlast
);
   import sgfb_pkg::*;

   // The pipeline moves whenever the output register is empty or being taken.
   logic advance;
   logic rsp_tvalid_ff;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   // Sigmoid stages.
   side_type       req_side;
   logic           sig_valid;
   logic [S_W-1:0] sig_s;
   side_type       sig_side;

   assign req_side.mode = req_tuser;
   assign req_side.last = req_tlast;
   assign req_side.grad = req_tdata[31:16];

   sgfb_sigmoid #(
      .TABLE_SEGMENTS (TABLE_SEGMENTS),
      .FRAC_BITS      (FRAC_BITS)
   ) u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_x      (req_tdata[15:0]),
      .in_side   (req_side),
      .out_valid (sig_valid),
      .out_s     (sig_s),
      .out_side  (sig_side)
   );

   // Stage 6: s*(1-s) and the magnitude and sign of the gradient.
   logic [DS_W-1:0] ds6_in;
   logic [AG_W-1:0] ag6_in;
   logic            vld6_ff;
   logic [DS_W-1:0] ds6_ff;
   logic [AG_W-1:0] ag6_ff;
   logic            gneg6_ff;
   logic [S_W-1:0]  s6_ff;
   logic            mode6_ff;
   logic            last6_ff;

   assign ds6_in = DS_W'(sig_s) * DS_W'(S_ONE - sig_s);
   assign ag6_in = sig_side.grad[GRAD_W-1] ? AG_W'(-sig_side.grad) : AG_W'(sig_side.grad);

   always_ff @(posedge clock) begin
      if (advance) begin
         ds6_ff   <= ds6_in;
         ag6_ff   <= ag6_in;
         gneg6_ff <= sig_side.grad[GRAD_W-1];
         s6_ff    <= sig_s;
         mode6_ff <= sig_side.mode;
         last6_ff <= sig_side.last;
      end
   end

   // Stage 7: full gradient product magnitude.
   logic [P_W-1:0] p7_in;
   logic           vld7_ff;
   logic [P_W-1:0] p7_ff;
   logic           gneg7_ff;
   logic [S_W-1:0] s7_ff;
   logic           mode7_ff;
   logic           last7_ff;

   assign p7_in = P_W'(ds6_ff) * P_W'(ag6_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         p7_ff    <= p7_in;
         gneg7_ff <= gneg6_ff;
         s7_ff    <= s6_ff;
         mode7_ff <= mode6_ff;
         last7_ff <= last6_ff;
      end
   end

   // Stage 8: round half away from zero, apply the sign, saturate, select by mode.
   logic [P_W-1:0] rnd8;
   logic [P_W-GRAD_SHIFT-1:0] m8;
   logic signed [Y_W-1:0] grad_y8;
   logic [Y_W-1:0]   y8_in;
   logic [Y_W-1:0]   rsp_y_ff;
   logic             rsp_last_ff;
   logic             rsp_mode_ff;

   assign rnd8 = p7_ff + (P_W'(1) << (GRAD_SHIFT - 1));
   assign m8   = rnd8[P_W-1:GRAD_SHIFT];

   always_comb begin
      if (!gneg7_ff) begin
         grad_y8 = (m8 > 15'd32767) ? 17'sd32767 : Y_W'(m8);
      end else begin
         grad_y8 = (m8 > 15'd32767) ? -17'sd32768 : -$signed(Y_W'(m8));
      end
   end

   assign y8_in = (mode7_ff == MODE_BACKWARD) ? Y_W'(grad_y8) : Y_W'(s7_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_y_ff    <= y8_in;
         rsp_last_ff <= last7_ff;
         rsp_mode_ff <= mode7_ff;
      end
   end

   // Valid bits of the gradient stages and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff       <= 1'b0;
         vld7_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         vld6_ff       <= sig_valid;
         vld7_ff       <= vld6_ff;
         rsp_tvalid_ff <= vld7_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_y_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A forward result is a sigmoid value in 0..1.
   a_forward_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (rsp_mode_ff == MODE_FORWARD) |->
         (rsp_y_ff[Y_W-1] == 1'b0) && (rsp_y_ff[S_W-1:0] <= S_ONE))
      else $error("forward result outside 0..1");

   // The interpolated sigmoid never reaches either end of its range.
   a_sigmoid_open: assert property (@(posedge clock) disable iff (reset)
      sig_valid |-> (sig_s != '0) && (sig_s < S_ONE))
      else $error("sigmoid value reached 0 or 1");

   // While the output waits, the items inside the pipeline stay where they are.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld7_ff) && $stable(vld6_ff) && $stable(p7_ff))
      else $error("pipeline moved during a stall");
`endif

endmodule
